[sv/bptc_pkg.sv]
// Package: payload structs and constants for the pressure/temperature compensator.
`default_nettype none
package bptc_pkg;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_tenths;
      logic [17:0]        pressure_pa;
      logic               div_error;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_CAL_A = 2'd0,
      CSR_CAL_B = 2'd1,
      CSR_CAL_C = 2'd2,
      CSR_OSS   = 2'd3
   } csr_index_type;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] B7_SCALE    = 32'd50000;
   localparam logic [31:0] B4_OFFSET   = 32'd32768;
   localparam logic [31:0] P_COEF_A    = 32'd3038;
   localparam logic [31:0] P_COEF_B    = 32'd7357;
   localparam logic [31:0] P_COEF_C    = 32'd3791;
   localparam int          DIV_STEPS   = 32;

endpackage
`default_nettype wire

[sv/bptc_div.sv]
// Pipelined restoring 32-bit unsigned divider, one quotient bit per stage.
`default_nettype none
module bptc_div
   import bptc_pkg::*;
#(
   parameter int SIDE_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [31:0]           in_dividend,
   input  wire logic [31:0]           in_divisor,
   input  wire logic [SIDE_WIDTH-1:0] in_side,
   output logic                       out_valid,
   output logic [31:0]                out_quotient,
   output logic [SIDE_WIDTH-1:0]      out_side
);

   // stage registers; remainder and divisor are not needed after the last stage
   logic [DIV_STEPS-1:0]          valid_ff;
   logic [31:0]                   quo_ff  [DIV_STEPS];
   logic [SIDE_WIDTH-1:0]         side_ff [DIV_STEPS];
   logic [31:0]                   rem_ff  [DIV_STEPS-1];
   logic [31:0]                   dvs_ff  [DIV_STEPS-1];

   // stage inputs
   logic [DIV_STEPS-1:0]          valid_s;
   logic [31:0]                   rem_s   [DIV_STEPS];
   logic [31:0]                   quo_s   [DIV_STEPS];
   logic [31:0]                   dvs_s   [DIV_STEPS];
   logic [SIDE_WIDTH-1:0]         side_s  [DIV_STEPS];
   logic [32:0]                   trial_in [DIV_STEPS];
   logic [32:0]                   diff_in  [DIV_STEPS];

   always_comb begin
      valid_s[0] = in_valid;
      rem_s[0]   = '0;
      quo_s[0]   = in_dividend;
      dvs_s[0]   = in_divisor;
      side_s[0]  = in_side;
      for (int s = 1; s < DIV_STEPS; s++) begin
         valid_s[s] = valid_ff[s-1];
         rem_s[s]   = rem_ff[s-1];
         quo_s[s]   = quo_ff[s-1];
         dvs_s[s]   = dvs_ff[s-1];
         side_s[s]  = side_ff[s-1];
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
         trial_in[s] = {rem_s[s], quo_s[s][31]};
         diff_in[s]  = trial_in[s] - {1'b0, dvs_s[s]};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_s[s];
         end
         quo_ff[s]  <= {quo_s[s][30:0], ~diff_in[s][32]};
         side_ff[s] <= side_s[s];
      end
      for (int s = 0; s < DIV_STEPS - 1; s++) begin
         rem_ff[s] <= diff_in[s][32] ? trial_in[s][31:0] : diff_in[s][31:0];
         dvs_ff[s] <= dvs_s[s];
      end
   end

   assign out_valid    = valid_ff[DIV_STEPS-1];
   assign out_quotient = quo_ff[DIV_STEPS-1];
   assign out_side     = side_ff[DIV_STEPS-1];

endmodule
`default_nettype wire

[sv/baro_pressure_temp_compensation.sv]
// Top level: pipelined integer pressure/temperature compensation.
//
//  channel | ports                              | transfer when
//  req     | start, busy, req_data              | start && !busy
//  rsp     | rsp_strobe, rsp_data               | rsp_strobe (no back-pressure)
//  csr     | csr_valid, csr_ready, csr_index/data | csr_valid && csr_ready
//
// One item enters per cycle; busy is tied low. The pipeline runs from the
// accepting edge to the edge that takes the result through 3 setup stages,
// 32 stages of the temperature divider, 5 pressure stages, 32 stages of the
// pressure divider and 3 output stages. Reset (synchronous) clears the
// valid bits and calibration registers. No stall exists: the receiver always
// takes the strobed result.
`default_nettype none
module baro_pressure_temp_compensation
   import bptc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   // ---------------- configuration ----------------
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CAL_A: cal_a_ff <= csr_data;
            CSR_CAL_B: cal_b_ff <= csr_data;
            CSR_CAL_C: cal_c_ff <= csr_data[31:0];
            CSR_OSS:   oss_ff   <= csr_data[1:0];
            default:   ;
         endcase
      end
   end

   // coefficients, extended to 32 bits (ac4, ac5, ac6 zero-extended, the rest sign-extended)
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   always_comb begin
      ac1 = {{16{cal_a_ff[63]}}, cal_a_ff[63:48]};
      ac2 = {{16{cal_a_ff[47]}}, cal_a_ff[47:32]};
      ac3 = {{16{cal_a_ff[31]}}, cal_a_ff[31:16]};
      ac4 = {16'd0, cal_a_ff[15:0]};
      ac5 = {16'd0, cal_b_ff[63:48]};
      ac6 = {16'd0, cal_b_ff[47:32]};
      b1  = {{16{cal_b_ff[31]}}, cal_b_ff[31:16]};
      b2  = {{16{cal_b_ff[15]}}, cal_b_ff[15:0]};
      mc  = {{16{cal_c_ff[31]}}, cal_c_ff[31:16]};
      md  = {{16{cal_c_ff[15]}}, cal_c_ff[15:0]};
   end

   function automatic logic [31:0] asr(input logic [31:0] u, input int s);
      asr = 32'($signed(u) >>> s);
   endfunction

   function automatic logic [31:0] neg(input logic [31:0] u);
      neg = 32'd0 - u;
   endfunction

   // ---------------- T1: ut - ac6, align pressure ----------------
   logic        t1_v_ff;
   logic [31:0] t1_d_ff, t1_up_ff;
   always_ff @(posedge clock) begin
      if (reset) t1_v_ff <= 1'b0;
      else       t1_v_ff <= start;
      t1_d_ff  <= {16'd0, req_data.raw_temperature} - ac6;
      t1_up_ff <= {8'd0, req_data.raw_pressure} >> (4'd8 - {2'd0, oss_ff});
   end

   // ---------------- T2: x1 = asr(d*ac5,15) ----------------
   logic        t2_v_ff;
   logic [31:0] t2_x1_ff, t2_up_ff;
   always_ff @(posedge clock) begin
      if (reset) t2_v_ff <= 1'b0;
      else       t2_v_ff <= t1_v_ff;
      t2_x1_ff <= asr(32'(t1_d_ff * ac5), 15);
      t2_up_ff <= t1_up_ff;
   end

   // ---------------- T3: den, signed divide setup ----------------
   logic        t3_v_ff;
   logic [31:0] t3_x1_ff, t3_up_ff, t3_num_ff, t3_den_ff;
   logic        t3_zero_ff, t3_negq_ff;
   logic [31:0] den_in, num_in;
   always_comb begin
      den_in = t2_x1_ff + md;
      num_in = mc << 11;
   end
   always_ff @(posedge clock) begin
      if (reset) t3_v_ff <= 1'b0;
      else       t3_v_ff <= t2_v_ff;
      t3_x1_ff   <= t2_x1_ff;
      t3_up_ff   <= t2_up_ff;
      t3_zero_ff <= (den_in == 32'd0);
      t3_negq_ff <= num_in[31] ^ den_in[31];
      t3_num_ff  <= num_in[31] ? neg(num_in) : num_in;
      t3_den_ff  <= den_in[31] ? neg(den_in) : den_in;
   end

   // side data through divider 1: x1, up, zero, negq
   localparam int S1W = 66;
   logic           d1_v;
   logic [31:0]    d1_q;
   logic [S1W-1:0] d1_side;
   bptc_div #(.SIDE_WIDTH(S1W)) u_div_t (
      .clock, .reset,
      .in_valid(t3_v_ff), .in_dividend(t3_num_ff),
      .in_divisor(t3_zero_ff ? 32'd1 : t3_den_ff),
      .in_side({t3_x1_ff, t3_up_ff, t3_zero_ff, t3_negq_ff}),
      .out_valid(d1_v), .out_quotient(d1_q), .out_side(d1_side)
   );

   // ---------------- P1: b5, b6 ----------------
   logic        p1_v_ff, p1_err_ff;
   logic [31:0] p1_b5_ff, p1_b6_ff, p1_up_ff;
   logic [31:0] x2t_in, b5_in;
   always_comb begin
      x2t_in = d1_side[0] ? neg(d1_q) : d1_q;
      b5_in  = d1_side[65:34] + x2t_in;
   end
   always_ff @(posedge clock) begin
      if (reset) p1_v_ff <= 1'b0;
      else       p1_v_ff <= d1_v;
      p1_err_ff <= d1_side[1];
      p1_up_ff  <= d1_side[33:2];
      p1_b5_ff  <= b5_in;
      p1_b6_ff  <= b5_in - B6_OFFSET;
   end

   // ---------------- P2: sq, ac2*b6, ac3*b6 ----------------
   logic        p2_v_ff, p2_err_ff;
   logic [31:0] p2_b5_ff, p2_up_ff, p2_sq_ff, p2_m2_ff, p2_m3_ff;
   always_ff @(posedge clock) begin
      if (reset) p2_v_ff <= 1'b0;
      else       p2_v_ff <= p1_v_ff;
      p2_err_ff <= p1_err_ff;
      p2_b5_ff  <= p1_b5_ff;
      p2_up_ff  <= p1_up_ff;
      p2_sq_ff  <= asr(32'(p1_b6_ff * p1_b6_ff), 12);
      p2_m2_ff  <= asr(32'(ac2 * p1_b6_ff), 11);
      p2_m3_ff  <= asr(32'(ac3 * p1_b6_ff), 13);
   end

   // ---------------- P3: b2*sq, b1*sq ----------------
   logic        p3_v_ff, p3_err_ff;
   logic [31:0] p3_b5_ff, p3_up_ff, p3_x3a_ff, p3_x3b_ff;
   logic [31:0] mb2_in, mb1_in;
   always_comb begin
      mb2_in = asr(32'(b2 * p2_sq_ff), 11);
      mb1_in = asr(32'(b1 * p2_sq_ff), 16);
   end
   always_ff @(posedge clock) begin
      if (reset) p3_v_ff <= 1'b0;
      else       p3_v_ff <= p2_v_ff;
      p3_err_ff <= p2_err_ff;
      p3_b5_ff  <= p2_b5_ff;
      p3_up_ff  <= p2_up_ff;
      p3_x3a_ff <= mb2_in + p2_m2_ff;
      p3_x3b_ff <= asr(p2_m3_ff + mb1_in + 32'd2, 2);
   end

   // ---------------- P4: b3, b4 ----------------
   logic        p4_v_ff, p4_err_ff;
   logic [31:0] p4_b5_ff, p4_d_ff, p4_b4_ff;
   logic [31:0] b3_in, b4p_in;
   always_comb begin
      b3_in  = asr(((ac1 * 32'd4 + p3_x3a_ff) << oss_ff) + 32'd2, 2);
      b4p_in = 32'(ac4 * (p3_x3b_ff + B4_OFFSET));
   end
   always_ff @(posedge clock) begin
      if (reset) p4_v_ff <= 1'b0;
      else       p4_v_ff <= p3_v_ff;
      p4_err_ff <= p3_err_ff;
      p4_b5_ff  <= p3_b5_ff;
      p4_d_ff   <= p3_up_ff - b3_in;
      p4_b4_ff  <= b4p_in >> 15;
   end

   // ---------------- P5: b7 ----------------
   logic        p5_v_ff, p5_err_ff;
   logic [31:0] p5_b5_ff, p5_b7_ff, p5_b4_ff;
   always_ff @(posedge clock) begin
      if (reset) p5_v_ff <= 1'b0;
      else       p5_v_ff <= p4_v_ff;
      p5_err_ff <= p4_err_ff || (p4_b4_ff == 32'd0);
      p5_b5_ff  <= p4_b5_ff;
      p5_b4_ff  <= p4_b4_ff;
      p5_b7_ff  <= 32'(p4_d_ff * (B7_SCALE >> oss_ff));
   end

   // side data through divider 2: b5, err, hi
   localparam int S2W = 34;
   logic           d2_v;
   logic [31:0]    d2_q;
   logic [S2W-1:0] d2_side;
   bptc_div #(.SIDE_WIDTH(S2W)) u_div_p (
      .clock, .reset,
      .in_valid(p5_v_ff),
      .in_dividend(p5_b7_ff[31] ? p5_b7_ff : (p5_b7_ff << 1)),
      .in_divisor(p5_b4_ff == 32'd0 ? 32'd1 : p5_b4_ff),
      .in_side({p5_b5_ff, p5_err_ff, p5_b7_ff[31]}),
      .out_valid(d2_v), .out_quotient(d2_q), .out_side(d2_side)
   );

   // ---------------- Q1: p, p>>8 squared, p*7357 ----------------
   logic        q1_v_ff, q1_err_ff;
   logic [31:0] q1_b5_ff, q1_p_ff, q1_sq_ff, q1_m_ff;
   logic [31:0] p_in, p8_in;
   always_comb begin
      p_in  = d2_side[0] ? (d2_q << 1) : d2_q;
      p8_in = asr(p_in, 8);
   end
   always_ff @(posedge clock) begin
      if (reset) q1_v_ff <= 1'b0;
      else       q1_v_ff <= d2_v;
      q1_err_ff <= d2_side[1];
      q1_b5_ff  <= d2_side[33:2];
      q1_p_ff   <= p_in;
      q1_sq_ff  <= 32'(p8_in * p8_in);
      q1_m_ff   <= asr(neg(32'(p_in * P_COEF_B)), 16);
   end

   // ---------------- Q2: *3038 ----------------
   logic        q2_v_ff, q2_err_ff;
   logic [31:0] q2_b5_ff, q2_p_ff, q2_x1_ff, q2_x2_ff;
   always_ff @(posedge clock) begin
      if (reset) q2_v_ff <= 1'b0;
      else       q2_v_ff <= q1_v_ff;
      q2_err_ff <= q1_err_ff;
      q2_b5_ff  <= q1_b5_ff;
      q2_p_ff   <= q1_p_ff;
      q2_x1_ff  <= asr(32'(q1_sq_ff * P_COEF_A), 16);
      q2_x2_ff  <= q1_m_ff;
   end

   // ---------------- Q3: final sum, saturate, strobe ----------------
   logic        rsp_v_ff;
   rsp_type     rsp_ff;
   logic [31:0] pf_in, t_in;
   always_comb begin
      pf_in = q2_p_ff + asr(q2_x1_ff + q2_x2_ff + P_COEF_C, 4);
      t_in  = asr(q2_b5_ff + 32'd8, 4);
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else       rsp_v_ff <= q2_v_ff;
      if (q2_err_ff) begin
         rsp_ff <= '{temperature_tenths: '0, pressure_pa: '0, div_error: 1'b1};
      end else begin
         rsp_ff.div_error <= 1'b0;
         if ($signed(t_in) > 32'sd32767)
            rsp_ff.temperature_tenths <= 16'sh7FFF;
         else if ($signed(t_in) < -32'sd32768)
            rsp_ff.temperature_tenths <= 16'sh8000;
         else
            rsp_ff.temperature_tenths <= t_in[15:0];
         if (pf_in[31])
            rsp_ff.pressure_pa <= '0;
         else if (pf_in > 32'd262143)
            rsp_ff.pressure_pa <= '1;
         else
            rsp_ff.pressure_pa <= pf_in[17:0];
      end
   end

   assign rsp_strobe = rsp_v_ff;
   assign rsp_data   = rsp_ff;

   // ---------------- checks ----------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.div_error |->
         rsp_data.pressure_pa == '0 && rsp_data.temperature_tenths == '0)
      else $error("error result carries nonzero payload");
   a_div1_in: assert property (@(posedge clock) disable iff (reset)
      p1_v_ff |-> $past(d1_v))
      else $error("stage P1 valid without divider output");
   a_no_stall: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for the pressure/temperature compensator: scoreboard, driver, stimulus.
`default_nettype none

module tb_top;
   import bptc_pkg::*;

   // Scoreboard: keeps the calibration copy, predicts each result, checks strobed results.
   class comp_scoreboard;
      logic [63:0] cal_a, cal_b;
      logic [31:0] cal_c;
      logic [1:0]  oss;
      rsp_type     pending[$];
      int          mismatches;
      int          unexpected;

      function new();
         cal_a = '0; cal_b = '0; cal_c = '0; oss = '0;
         mismatches = 0; unexpected = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [63:0] value);
         case (idx)
            CSR_CAL_A: cal_a = value;
            CSR_CAL_B: cal_b = value;
            CSR_CAL_C: cal_c = value[31:0];
            CSR_OSS:   oss   = value[1:0];
            default:   ;
         endcase
      endfunction

      static function logic [31:0] asr(logic [31:0] u, int s);
         return $signed(u) >>> s;
      endfunction

      static function logic [31:0] sext(logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      // Integer compensation, everything wraps at 32 bits.
      function rsp_type compensate(req_type item);
         rsp_type     r;
         logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
         logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, den;
         int          num, dsg, t, ps;
         ac1 = sext(cal_a[63:48]); ac2 = sext(cal_a[47:32]);
         ac3 = sext(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
         ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
         b1  = sext(cal_b[31:16]); b2 = sext(cal_b[15:0]);
         mc  = sext(cal_c[31:16]); md = sext(cal_c[15:0]);
         ut  = {16'd0, item.raw_temperature};
         up  = {8'd0, item.raw_pressure} >> (8 - oss);
         r   = '0;
         x1  = asr((ut - ac6) * ac5, 15);
         den = x1 + md;
         if (den == 0) begin
            r.div_error = 1'b1;
            return r;
         end
         num = mc * 2048;
         dsg = den;
         x2  = num / dsg;           // signed, truncates toward zero
         b5  = x1 + x2;
         b6  = b5 - B6_OFFSET;
         sq  = asr(b6 * b6, 12);
         x1  = asr(b2 * sq, 11);
         x2  = asr(ac2 * b6, 11);
         x3  = x1 + x2;
         b3  = asr(((ac1 * 4 + x3) << oss) + 2, 2);
         x1  = asr(ac3 * b6, 13);
         x2  = asr(b1 * sq, 16);
         x3  = asr(x1 + x2 + 2, 2);
         b4  = (ac4 * (x3 + B4_OFFSET)) >> 15;
         if (b4 == 0) begin
            r.div_error = 1'b1;
            return r;
         end
         b7 = (up - b3) * (B7_SCALE >> oss);
         if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
         else p = (b7 / b4) << 1;
         x1 = asr(p, 8) * asr(p, 8);
         x1 = asr(x1 * P_COEF_A, 16);
         x2 = asr(32'd0 - p * P_COEF_B, 16);
         p  = p + asr(x1 + x2 + P_COEF_C, 4);
         t  = asr(b5 + 8, 4);
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         ps = p;
         if (ps < 0) ps = 0;
         if (ps > 262143) ps = 262143;
         r.temperature_tenths = t[15:0];
         r.pressure_pa        = ps[17:0];
         return r;
      endfunction

      function void note_sample(req_type item);
         pending.push_back(compensate(item));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            unexpected++;
            if (unexpected + mismatches <= 10)
               $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.temperature_tenths !== want.temperature_tenths ||
             got.pressure_pa !== want.pressure_pa || got.div_error !== want.div_error) begin
            mismatches++;
            if (unexpected + mismatches <= 10)
               $display("mismatch: expected t=%0d p=%0d e=%0b, got t=%0d p=%0d e=%0b",
                        want.temperature_tenths, want.pressure_pa, want.div_error,
                        got.temperature_tenths, got.pressure_pa, got.div_error);
         end
      endfunction
   endclass

   // Typical factory calibration, used as the base of most settings.
   localparam logic [63:0] NOMINAL_A = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
   localparam logic [63:0] NOMINAL_B = {16'd32757, 16'd23153, 16'd6190, 16'd4};
   localparam logic [31:0] NOMINAL_C = {16'hDDF9, 16'd2868};
   localparam int          DRAIN_CYCLES = 120;
   localparam int          STALL_LIMIT  = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   comp_scoreboard board = new();
   int  sent = 0;
   int  idle_pct = 16;
   int  quiet_cycles = 0;

   always #4 clock = ~clock;

   baro_pressure_temp_compensation uut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // Monitors: sample at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && start && !busy) board.note_sample(req_data);
      if (!reset && rsp_strobe) board.check_result(rsp_data);
   end

   // Watchdog: cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // One sample transfer; start stays high if the next item follows at once.
   task automatic send_sample(logic [15:0] ut, logic [23:0] rp);
      req_type item;
      item.raw_temperature = ut;
      item.raw_pressure    = rp;
      start    <= 1'b1;
      req_data <= item;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
   endtask

   // Wait for the pipeline to empty before a register write.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; load_cal drops it.
   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      board.set_reg(idx, value);
   endtask

   task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [1:0] o);
      drain();
      write_reg(CSR_CAL_A, a);
      write_reg(CSR_CAL_B, b);
      write_reg(CSR_CAL_C, c);
      write_reg(CSR_OSS, {62'd0, o});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      logic [63:0] a, b;
      logic [31:0] c;
      logic [15:0] ut;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: all-zero calibration gives a zero temperature divisor.
      send_sample(16'd0, 24'd0);
      send_sample(16'hFFFF, 24'hFFFFFF);

      // Nominal calibration, no oversampling, field extremes.
      load_cal(NOMINAL_A, NOMINAL_B, NOMINAL_C, 2'd0);
      send_sample(16'd27898, 24'd23843 << 8);
      send_sample(16'd0, 24'd0);
      send_sample(16'hFFFF, 24'hFFFFFF);
      send_sample(16'd0, 24'hFFFFFF);
      send_sample(16'hFFFF, 24'd0);

      // Highest oversampling.
      load_cal(NOMINAL_A, NOMINAL_B, NOMINAL_C, 2'd3);
      send_sample(16'd27898, 24'd23843 << 5);
      send_sample(16'd0, 24'hFFFFFF);
      send_sample(16'hFFFF, 24'd0);

      // ac4 zero: temperature fine, pressure divisor zero.
      load_cal({NOMINAL_A[63:16], 16'd0}, NOMINAL_B, NOMINAL_C, 2'd1);
      send_sample(16'd27898, 24'd23843 << 7);
      send_sample(16'hFFFF, 24'hFFFFFF);

      // md cancels x1 exactly: ut == ac6 gives x1 = 0, so md = 0 makes den zero.
      load_cal(NOMINAL_A, NOMINAL_B, {NOMINAL_C[31:16], 16'd0}, 2'd2);
      send_sample(16'd23153, 24'd23843 << 6);
      send_sample(16'd27898, 24'd23843 << 6);

      // All-ones calibration: wild intermediates, saturation.
      load_cal({64{1'b1}}, {64{1'b1}}, {32{1'b1}}, 2'd3);
      send_sample(16'hFFFF, 24'hFFFFFF);
      send_sample(16'd0, 24'd0);
      send_sample(16'h8000, 24'h800000);

      // Random phases; idling schedule moves on with the item count.
      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 3 == 2) begin
            a = rand64(); b = rand64(); c = $urandom();
         end else begin
            // Nominal values with jitter in the low bits of every coefficient.
            a = NOMINAL_A ^ {4{12'd0, 4'($urandom())}};
            b = NOMINAL_B ^ {4{12'd0, 4'($urandom())}};
            c = NOMINAL_C ^ {2{12'd0, 4'($urandom())}};
         end
         load_cal(a, b, c, 2'($urandom()));
         for (int k = 0; k < 44; k++) begin
            idle_pct = (sent < 150) ? 16 : (sent < 300) ? 84 : 0;
            if ($urandom_range(3) == 0) ut = $urandom();
            else ut = 16'(27898 + $urandom_range(8191) - 4096);
            send_sample(ut, 24'($urandom()));
         end
      end

      drain();
      if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

`default_nettype wire
